@@ design/ctia_pkg.sv @@
// ctia_pkg: shared types, constants and field widths of the centroid track id assigner.
// No dependencies.
package ctia_pkg;

  localparam int MAX_PEOPLE_DEF = 16;

  localparam logic [1:0] MODE_DET = 2'd0;
  localparam logic [1:0] MODE_EOF = 2'd1;
  localparam logic [1:0] MODE_RST = 2'd2;

  localparam logic [15:0] MIN_CONF_RST = 16'hFE80;  // -1.5 in Q8.8
  localparam logic [15:0] MATCH_DIST_RST = 16'd300;

  localparam logic CFG_MIN_CONF = 1'b0;
  localparam logic CFG_MATCH_DIST = 1'b1;

  // one table entry: x, y, z, id from the low bits up
  typedef struct packed {
    logic [15:0] id;
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } entry_t;

  // word queued from front to back
  typedef struct packed {
    logic [1:0] mode;
    logic accepted;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic accepted;
    logic matched;
    logic [15:0] person_id;
    logic stored;
    logic [7:0] people_in_frame;
    logic history_cleared;
  } res_t;

  function automatic logic [16:0] abs_diff(logic signed [15:0] a, logic signed [15:0] b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    abs_diff = d[16] ? 17'(-d) : d;
  endfunction

endpackage

@@ design/ctia_ram.sv @@
// ctia_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ctia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ design/ctia_front.sv @@
// ctia_front: accepts input words, applies the confidence threshold, pushes commands
// into a two-entry queue. Depends on ctia_pkg.
module ctia_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_mode,
  input  logic signed [15:0]   in_conf,
  input  logic signed [15:0]   in_x,
  input  logic signed [15:0]   in_y,
  input  logic signed [15:0]   in_z,
  input  logic signed [15:0]   min_conf,
  output logic                 q_valid,
  output ctia_pkg::cmd_t       q_data,
  input  logic                 q_pop
);
  import ctia_pkg::*;

  cmd_t q_r [2];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;
  cmd_t c;
  logic push;

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = q_r[rd_r];

  always_comb begin
    c.mode = in_mode;
    c.accepted = (in_mode == MODE_DET) && (in_conf > min_conf);
    c.x = in_x;
    c.y = in_y;
    c.z = in_z;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= c;
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

@@ design/ctia_back.sv @@
// ctia_back: executes queued commands: scans the previous table, assigns ids,
// stores entries, swaps tables at frame end. Depends on ctia_pkg and ctia_ram.
module ctia_back #(
  parameter int MAX_PEOPLE = ctia_pkg::MAX_PEOPLE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ctia_pkg::cmd_t q_data,
  output logic           q_pop,
  input  logic [15:0]    match_dist,
  output logic           res_valid,
  output ctia_pkg::res_t res_data,
  input  logic           res_ready
);
  import ctia_pkg::*;

  localparam int AW = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
  localparam int CW = $clog2(MAX_PEOPLE + 1);
  localparam int D  = 1 << AW;
  localparam logic [CW-1:0] FULL = CW'(MAX_PEOPLE);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CHK  = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic bank_r;  // bank holding the previous table
  logic [CW-1:0] prev_cnt_r, cur_cnt_r;
  logic [7:0] acc_cnt_r;
  logic [15:0] id_r;
  logic [1:0] empty_r;
  logic [CW-1:0] idx_r;
  cmd_t cmd_r;
  logic res_valid_r;
  res_t res_r;

  logic [AW-1:0] raddr;
  entry_t rd0, rd1, e;
  logic we0, we1;
  entry_t wentry;
  logic [15:0] new_id;
  logic hit;

  assign raddr = idx_r[AW-1:0];
  assign e = bank_r ? rd1 : rd0;
  assign hit = (abs_diff(e.x, cmd_r.x) < {1'b0, match_dist}) &&
               (abs_diff(e.y, cmd_r.y) < {1'b0, match_dist}) &&
               (abs_diff(e.z, cmd_r.z) < {1'b0, match_dist});

  ctia_ram #(.WIDTH($bits(entry_t)), .DEPTH(D)) u_ram0 (
    .clk(clk), .we(we0), .waddr(cur_cnt_r[AW-1:0]), .wdata(wentry),
    .raddr(raddr), .rdata(rd0));
  ctia_ram #(.WIDTH($bits(entry_t)), .DEPTH(D)) u_ram1 (
    .clk(clk), .we(we1), .waddr(cur_cnt_r[AW-1:0]), .wdata(wentry),
    .raddr(raddr), .rdata(rd1));

  logic out_free;
  assign out_free = !res_valid_r || res_ready;
  assign res_valid = res_valid_r;
  assign res_data = res_r;
  assign new_id = id_r + 16'd1;

  // store of a finished detection: to the current bank (not bank_r)
  logic store_go;
  logic [15:0] store_id;
  logic store_match;
  always_comb begin
    store_go = 1'b0;
    store_id = new_id;
    store_match = 1'b0;
    if (st_r == ST_CHK && out_free) begin
      if (hit) begin
        store_go = 1'b1;
        store_id = e.id;
        store_match = 1'b1;
      end else if (idx_r + CW'(1) >= prev_cnt_r) begin
        store_go = 1'b1;
      end
    end else if (st_r == ST_SCAN && out_free && prev_cnt_r == '0) begin
      store_go = 1'b1;
    end
    wentry.x = cmd_r.x;
    wentry.y = cmd_r.y;
    wentry.z = cmd_r.z;
    wentry.id = store_id;
    we0 = store_go && (cur_cnt_r < FULL) && bank_r;
    we1 = store_go && (cur_cnt_r < FULL) && !bank_r;
  end

  // commands other than accepted detections are only taken when the result register is free
  assign q_pop = (st_r == ST_IDLE) && q_valid && (q_data.accepted || out_free);

  logic res_load;
  assign res_load = (q_pop && !q_data.accepted) || store_go;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid && q_data.accepted) st_nxt = ST_SCAN;
      ST_SCAN: if (prev_cnt_r == '0) begin
        if (out_free) st_nxt = ST_IDLE;
      end else st_nxt = ST_CHK;
      ST_CHK: if (store_go) st_nxt = ST_IDLE;
        else if (!hit && out_free) st_nxt = ST_SCAN;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      bank_r <= 1'b0;
      prev_cnt_r <= '0;
      cur_cnt_r <= '0;
      acc_cnt_r <= '0;
      id_r <= '0;
      empty_r <= '0;
      idx_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      res_valid_r <= res_load || (res_valid_r && !res_ready);
      if (q_pop) begin
        cmd_r <= q_data;
        idx_r <= '0;
      end
      if (st_r == ST_CHK && !hit && out_free && !store_go) idx_r <= idx_r + CW'(1);
      if (q_pop && !q_data.accepted && out_free) begin
        // commands other than accepted detections
        res_r <= '{kind: q_data.mode, accepted: 1'b0, matched: 1'b0, person_id: 16'd0,
                   stored: 1'b0,
                   people_in_frame: (q_data.mode == MODE_EOF) ? acc_cnt_r : 8'd0,
                   history_cleared: (q_data.mode == MODE_EOF) && (acc_cnt_r == 8'd0) &&
                                    (empty_r == 2'd2)};
        if (q_data.mode == MODE_EOF) begin
          if (acc_cnt_r == 8'd0) begin
            if (empty_r != 2'd3) begin
              empty_r <= empty_r + 2'd1;
              if (empty_r == 2'd2) begin
                prev_cnt_r <= '0;
              end
            end
          end else begin
            empty_r <= '0;
            bank_r <= ~bank_r;
            prev_cnt_r <= cur_cnt_r;
          end
          cur_cnt_r <= '0;
          acc_cnt_r <= '0;
        end else if (q_data.mode == MODE_RST) begin
          prev_cnt_r <= '0;
          cur_cnt_r <= '0;
          acc_cnt_r <= '0;
          id_r <= '0;
          empty_r <= '0;
        end
      end
      if (store_go) begin
        res_r <= '{kind: MODE_DET, accepted: 1'b1, matched: store_match,
                   person_id: store_id, stored: (cur_cnt_r < FULL),
                   people_in_frame: 8'd0, history_cleared: 1'b0};
        if (!store_match) id_r <= new_id;
        if (cur_cnt_r < FULL) cur_cnt_r <= cur_cnt_r + CW'(1);
        if (acc_cnt_r != 8'hFF) acc_cnt_r <= acc_cnt_r + 8'd1;
      end
    end
  end
endmodule

@@ design/centroid_track_id_assigner.sv @@
// centroid_track_id_assigner: top level; front classifier, command queue, back executor.
// Depends on ctia_pkg, ctia_front, ctia_back, ctia_ram.
//
// Each input word yields one result word. A detection above the confidence threshold scans
// the previous-frame table one entry at a time (a RAM read, then a gate compare per entry)
// and stops at the first match; end of frame, restart and rejected detections are taken
// once the result register is free. The tables live in two RAM banks that swap roles at a
// non-empty frame end, so no copy is needed. A two-word queue lets the input side keep
// accepting while the back end scans or waits on the output.
module centroid_track_id_assigner #(
  parameter int MAX_PEOPLE = ctia_pkg::MAX_PEOPLE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode
  input  logic [63:0] in_tdata,   // confidence, pos_x, pos_y, pos_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // kind
  output logic [31:0] out_tdata,  // accepted, matched, person_id, stored,
                                  // people_in_frame, history_cleared, 4 zero bits
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import ctia_pkg::*;

  logic [15:0] min_conf_r, match_dist_r;
  logic q_valid, q_pop, res_valid;
  cmd_t q_data;
  res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_conf_r <= MIN_CONF_RST;
      match_dist_r <= MATCH_DIST_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MIN_CONF) min_conf_r <= cfg_data;
      else match_dist_r <= cfg_data;
    end
  end

  ctia_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_mode(in_tuser),
    .in_conf(in_tdata[15:0]), .in_x(in_tdata[31:16]), .in_y(in_tdata[47:32]),
    .in_z(in_tdata[63:48]), .min_conf(min_conf_r),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop));

  ctia_back #(.MAX_PEOPLE(MAX_PEOPLE)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .match_dist(match_dist_r), .res_valid(res_valid), .res_data(res),
    .res_ready(out_tready));

  assign out_tvalid = res_valid;
  assign out_tuser = res.kind;
  assign out_tdata = {4'd0, res.history_cleared, res.people_in_frame, res.stored,
                      res.person_id, res.matched, res.accepted};
endmodule

@@ sim/tb_centroid_track_id_assigner.sv @@
// Testbench for centroid_track_id_assigner: streams detection, frame-end and restart
// words, predicts each result word in a local model and checks it. Depends on ctia_pkg.
`timescale 1ns / 100ps

module tb_centroid_track_id_assigner;
  import ctia_pkg::*;

  localparam int NTRK = MAX_PEOPLE_DEF;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [15:0] id;
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } track_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  centroid_track_id_assigner u_top (.*);

  initial forever #6 clk = ~clk;

  // predictor state
  logic signed [15:0] thr_conf;
  logic [15:0]        gate_mm;
  track_t             prev_trk [NTRK];
  track_t             cur_trk  [NTRK];
  int                 prev_n, cur_n;
  logic [7:0]         det_cnt;
  logic [15:0]        next_id;
  logic [1:0]         empty_frames;

  res_t   result_q [$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     hold_rx = 1'b0;  // long receiver hold-off
  int     rx_gap_max = 3;

  function automatic logic [16:0] dist_mm(logic signed [15:0] a, logic signed [15:0] b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    return d[16] ? 17'(-d) : d;
  endfunction

  function automatic void clear_tracks();
    prev_n = 0; cur_n = 0; det_cnt = 0; next_id = 0; empty_frames = 0;
  endfunction

  function automatic res_t track_assign(logic [1:0] mode, logic [63:0] d);
    res_t r;
    logic signed [15:0] c, px, py, pz;
    r = '0;
    r.kind = mode;
    c = d[15:0]; px = d[31:16]; py = d[47:32]; pz = d[63:48];
    if (mode == MODE_DET) begin
      if (c > thr_conf) begin
        r.accepted = 1'b1;
        for (int i = 0; i < prev_n; i++) begin
          if (dist_mm(prev_trk[i].x, px) < 17'(gate_mm) &&
              dist_mm(prev_trk[i].y, py) < 17'(gate_mm) &&
              dist_mm(prev_trk[i].z, pz) < 17'(gate_mm)) begin
            r.matched = 1'b1;
            r.person_id = prev_trk[i].id;
            break;
          end
        end
        if (!r.matched) begin
          next_id = next_id + 16'd1;
          r.person_id = next_id;
        end
        if (cur_n < NTRK) begin
          cur_trk[cur_n] = '{id: r.person_id, z: pz, y: py, x: px};
          cur_n++;
          r.stored = 1'b1;
        end
        if (det_cnt != 8'd255) det_cnt++;
      end
    end else if (mode == MODE_EOF) begin
      r.people_in_frame = det_cnt;
      if (det_cnt == 0) begin
        if (empty_frames != 2'd3) begin
          empty_frames++;
          if (empty_frames == 2'd3) begin
            prev_n = 0;
            r.history_cleared = 1'b1;
          end
        end
      end else begin
        empty_frames = 0;
        prev_trk = cur_trk;
        prev_n = cur_n;
      end
      cur_n = 0;
      det_cnt = 0;
    end else if (mode == MODE_RST) begin
      clear_tracks();
    end
    return r;
  endfunction

  function automatic int rand_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // one word to the block; prediction taken at acceptance; valid stays up for a
  // following word sent without a gap
  task automatic send_word(logic [1:0] mode, logic signed [15:0] c,
                           logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, bit gaps = 1);
    int g;
    g = gaps ? rand_gap() : 0;
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {z, y, x, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    result_q.insert(result_q.size(), track_assign(mode, {z, y, x, c}));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MIN_CONF) thr_conf = val;
    else gate_mm = val;
    @(posedge clk);
  endtask

  // receiver: random stalls, or a long hold-off on request
  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (hold_rx) out_tready <= 1'b0;
      else begin
        g = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(0, rx_gap_max);
        out_tready <= (g == 0);
        if (g > 1) begin
          repeat (g - 1) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  // result checker
  initial begin
    res_t got, exp_r;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.accepted = out_tdata[0];
        got.matched = out_tdata[1];
        got.person_id = out_tdata[17:2];
        got.stored = out_tdata[18];
        got.people_in_frame = out_tdata[26:19];
        got.history_cleared = out_tdata[27];
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %p", got);
        end else begin
          exp_r = result_q.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10) $display("result mismatch: exp %p got %p", exp_r, got);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !in_tvalid
          && result_q.size() == 0) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("centroid_track_id_assigner: mismatch");
        $finish;
      end
    end
  end

  // random position near a small set of people so matches happen
  function automatic logic signed [15:0] near(logic signed [15:0] base);
    return base + 16'($signed($urandom_range(0, 700)) - 350);
  endfunction

  task automatic test_directed();
    send_word(MODE_DET, -16'sd384, 0, 0, 0);          // at threshold: rejected
    send_word(MODE_DET, -16'sd383, 100, 200, 300);    // just above
    send_word(MODE_DET, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_word(MODE_DET, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_word(MODE_EOF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(MODE_DET, 16'sd256, 399, 200, 300);     // diff 299: match
    send_word(MODE_DET, 16'sd256, 400, 200, 300);     // diff 300: new id
    send_word(MODE_DET, 16'sd256, -16'sd32768, 16'sh7FFF, -16'sd32768);
    send_word(MODE_EOF, 0, 0, 0, 0);
    for (int i = 0; i < 3; i++) send_word(MODE_EOF, 0, 0, 0, 0);  // history clear
    send_word(MODE_EOF, 0, 0, 0, 0);                  // stays cleared
    send_word(2'd3, 16'sd1000, 1, 2, 3);              // unknown mode
    for (int i = 0; i < 18; i++) send_word(MODE_DET, 16'sd500, 16'(i * 1000), 0, 0); // table full
    send_word(MODE_EOF, 0, 0, 0, 0);
    send_word(MODE_RST, 16'h1234, 5, 6, 7);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_MIN_CONF, 16'h8000);
    write_reg(CFG_MATCH_DIST, 16'hFFFF);
    send_word(MODE_DET, 16'sh8001, 16'sh8000, 16'sh8000, 16'sh8000);
    send_word(MODE_EOF, 0, 0, 0, 0);
    send_word(MODE_DET, 16'sh8001, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);  // diff 65535
    send_word(MODE_DET, 16'sh8000, 0, 0, 0);
    drain();
    write_reg(CFG_MIN_CONF, 16'h7FFF);
    write_reg(CFG_MATCH_DIST, 16'h0000);
    send_word(MODE_DET, 16'sh7FFF, 0, 0, 0);          // never accepted
    send_word(MODE_EOF, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_fresh_ids();
    write_reg(CFG_MIN_CONF, 16'h8000);
    write_reg(CFG_MATCH_DIST, 16'd0);                 // nothing matches
    send_word(MODE_RST, 0, 0, 0, 0);
    for (int i = 0; i < 48; i++) begin
      send_word(MODE_DET, 16'sd0, 16'($urandom), 16'($urandom), 16'($urandom), 0);
      if (i % 16 == 15) send_word(MODE_EOF, 0, 0, 0, 0, 0);
    end
    send_word(MODE_EOF, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_random(int n_items);
    logic signed [15:0] ppl [4][3];
    logic signed [15:0] c;
    int k, r;
    for (int p = 0; p < 4; p++)
      for (int a = 0; a < 3; a++) ppl[p][a] = 16'($urandom);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      c = 16'($urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 1200)) - 600);
      if (r < 70) begin
        k = $urandom_range(0, 3);
        send_word(MODE_DET, c, near(ppl[k][0]), near(ppl[k][1]), near(ppl[k][2]));
      end else if (r < 80) send_word(MODE_DET, c, 16'($urandom), 16'($urandom), 16'($urandom));
      else if (r < 96) send_word(MODE_EOF, 16'($urandom), 16'($urandom), 0, 0);
      else if (r < 98) send_word(MODE_RST, 16'($urandom), 0, 0, 0);
      else send_word(2'd3, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin repeat (300) @(posedge clk); hold_rx = 1'b0; end
      for (int i = 0; i < 12; i++) send_word(MODE_DET, 16'sd100, 16'(i * 50), 0, 0, 0);
    join
    drain();
  endtask

  initial begin
    thr_conf = MIN_CONF_RST;
    gate_mm = MATCH_DIST_RST;
    clear_tracks();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    write_reg(CFG_MIN_CONF, 16'hFE80);
    write_reg(CFG_MATCH_DIST, 16'd300);
    test_random(900);
    test_backpressure();
    write_reg(CFG_MIN_CONF, 16'd0);
    write_reg(CFG_MATCH_DIST, 16'd1000);
    rx_gap_max = 1;
    test_random(900);
    rx_gap_max = 0;
    test_fresh_ids();
    if (errors == 0) $display("centroid_track_id_assigner: match");
    else $display("centroid_track_id_assigner: mismatch");
    $finish;
  end

endmodule
